### hdl/paf_pkg.sv
// ----------------------------------------------------------------------------
// Point attraction force: shared types and constants
// Field widths, internal datapath widths and the structures that travel
// between the pipeline sections of the point attraction force core.
// ----------------------------------------------------------------------------
package paf_pkg;

	// Port field widths.
	localparam int POS_W     = 24;
	localparam int ACC_W     = 32;
	localparam int STR_W     = 24;
	localparam int SOFT_W    = 32;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;

	// Datapath widths.
	localparam int DIFF_W     = POS_W + 1;          // centre minus position
	localparam int MAG_W      = POS_W + 1;          // magnitude, up to 2^24
	localparam int SQ_W       = 2 * MAG_W;          // squared magnitude
	localparam int D_W        = 2 * MAG_W;          // softened squared distance
	localparam int ROOT_W     = D_W / 2;            // integer square root
	localparam int ROOT_SPLIT = D_W / 2;            // split of D for the product
	localparam int SQRT_W     = D_W + 1;            // square root working width
	localparam int SQRT_STEPS = ROOT_W;             // one root bit per stage
	localparam int PROD_W     = STR_W + MAG_W - 1;  // strength times magnitude
	localparam int DEN_W      = D_W + ROOT_W;       // D times root
	localparam int REM_W      = DEN_W + 1;          // divider remainder
	localparam int QUO_W      = 40;                 // quotient bits below the cap
	localparam int DIV_STEPS  = QUO_W;              // one quotient bit per stage
	localparam int QF_W       = QUO_W + 1;          // quotient including the cap
	localparam int CON_W      = QF_W + 1;           // signed contribution
	localparam int SUM_W      = CON_W + 1;          // acceleration plus contribution

	localparam logic [SOFT_W-1:0] SOFT_RESET = SOFT_W'(109951163);

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X  = 2'd0,
		REG_CENTER_Y  = 2'd1,
		REG_STRENGTH  = 2'd2,
		REG_SOFTENING = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [POS_W-1:0]  center_x;
		logic [POS_W-1:0]  center_y;
		logic [STR_W-1:0]  strength;
		logic [SOFT_W-1:0] softening;
	} cfg_regs_t;

	// Per-particle data carried alongside the root and divider pipelines.
	typedef struct packed {
		logic [ACC_W-1:0]  acc_x;
		logic [ACC_W-1:0]  acc_y;
		logic              neg_x;
		logic              neg_y;
		logic [PROD_W-1:0] p_x;
		logic [PROD_W-1:0] p_y;
		logic              last;
	} side_t;

endpackage

### hdl/paf_if.sv
// ----------------------------------------------------------------------------
// Point attraction force: channel interfaces
// Valid/ready channels for particle items in and acceleration results out.
// ----------------------------------------------------------------------------
interface paf_in_if import paf_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic signed [ACC_W-1:0] accel_x_in;
	logic signed [ACC_W-1:0] accel_y_in;
	logic                    last_particle;

	modport source (output valid, pos_x, pos_y, accel_x_in, accel_y_in, last_particle,
		input ready);
	modport sink (input valid, pos_x, pos_y, accel_x_in, accel_y_in, last_particle,
		output ready);
endinterface

interface paf_out_if import paf_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [ACC_W-1:0] accel_x_out;
	logic signed [ACC_W-1:0] accel_y_out;
	logic                    saturated;
	logic                    last_out;

	modport source (output valid, accel_x_out, accel_y_out, saturated, last_out,
		input ready);
	modport sink (input valid, accel_x_out, accel_y_out, saturated, last_out,
		output ready);
endinterface

### hdl/paf_front.sv
// ----------------------------------------------------------------------------
// Point attraction force: front end
// Four stages: offsets from the centre, magnitudes, squares and strength
// products, then the softened squared distance.
// ----------------------------------------------------------------------------
module paf_front import paf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             valid_in,
	input  logic [POS_W-1:0] pos_x,
	input  logic [POS_W-1:0] pos_y,
	input  logic [ACC_W-1:0] accel_x_in,
	input  logic [ACC_W-1:0] accel_y_in,
	input  logic             last_particle,
	input  cfg_regs_t        cfg,
	output logic             valid_out,
	output logic [D_W-1:0]   d_out,
	output side_t            side_out
);

	logic                    v_s1, v_s2, v_s3, v_s4;
	logic [DIFF_W-1:0]       dx_s1, dy_s1;
	logic [ACC_W-1:0]        ax_s1, ay_s1, ax_s2, ay_s2, ax_s3, ay_s3;
	logic                    last_s1, last_s2, last_s3;
	logic                    neg_x_s2, neg_y_s2, neg_x_s3, neg_y_s3;
	logic [MAG_W-1:0]        mag_x_s2, mag_y_s2;
	logic [SQ_W-1:0]         sq_x_s3, sq_y_s3;
	logic [PROD_W-1:0]       p_x_s3, p_y_s3;
	logic [D_W-1:0]          d_s4;
	side_t                   side_s4;

	logic [DIFF_W-1:0]       dx_c, dy_c;
	logic [MAG_W-1:0]        mag_x_c, mag_y_c;
	logic [SQ_W-1:0]         sq_x_c, sq_y_c;
	logic [STR_W+MAG_W-1:0]  pw_x_c, pw_y_c;
	logic [D_W-1:0]          d_c;

	// Offsets from the centre, sign extended by one bit.
	assign dx_c = {cfg.center_x[POS_W-1], cfg.center_x} - {pos_x[POS_W-1], pos_x};
	assign dy_c = {cfg.center_y[POS_W-1], cfg.center_y} - {pos_y[POS_W-1], pos_y};

	// Magnitudes; the most negative offset still fits unsigned.
	assign mag_x_c = dx_s1[DIFF_W-1] ? MAG_W'(-dx_s1) : MAG_W'(dx_s1);
	assign mag_y_c = dy_s1[DIFF_W-1] ? MAG_W'(-dy_s1) : MAG_W'(dy_s1);

	// Squares and strength products.
	assign sq_x_c = SQ_W'(mag_x_s2) * SQ_W'(mag_x_s2);
	assign sq_y_c = SQ_W'(mag_y_s2) * SQ_W'(mag_y_s2);
	assign pw_x_c = (STR_W+MAG_W)'(cfg.strength) * (STR_W+MAG_W)'(mag_x_s2);
	assign pw_y_c = (STR_W+MAG_W)'(cfg.strength) * (STR_W+MAG_W)'(mag_y_s2);

	// Softened squared distance, always below 2^50.
	assign d_c = sq_x_s3 + sq_y_s3 + D_W'(cfg.softening);

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1    <= dx_c;
			dy_s1    <= dy_c;
			ax_s1    <= accel_x_in;
			ay_s1    <= accel_y_in;
			last_s1  <= last_particle;

			neg_x_s2 <= dx_s1[DIFF_W-1];
			neg_y_s2 <= dy_s1[DIFF_W-1];
			mag_x_s2 <= mag_x_c;
			mag_y_s2 <= mag_y_c;
			ax_s2    <= ax_s1;
			ay_s2    <= ay_s1;
			last_s2  <= last_s1;

			sq_x_s3  <= sq_x_c;
			sq_y_s3  <= sq_y_c;
			p_x_s3   <= pw_x_c[PROD_W-1:0];
			p_y_s3   <= pw_y_c[PROD_W-1:0];
			neg_x_s3 <= neg_x_s2;
			neg_y_s3 <= neg_y_s2;
			ax_s3    <= ax_s2;
			ay_s3    <= ay_s2;
			last_s3  <= last_s2;

			d_s4          <= d_c;
			side_s4.acc_x <= ax_s3;
			side_s4.acc_y <= ay_s3;
			side_s4.neg_x <= neg_x_s3;
			side_s4.neg_y <= neg_y_s3;
			side_s4.p_x   <= p_x_s3;
			side_s4.p_y   <= p_y_s3;
			side_s4.last  <= last_s3;
		end
	end

	assign valid_out = v_s4;
	assign d_out     = d_s4;
	assign side_out  = side_s4;

endmodule

### hdl/paf_sqrt.sv
// ----------------------------------------------------------------------------
// Point attraction force: pipelined integer square root
// One root bit per stage, digit by digit; the operand and the particle data
// travel alongside.
// ----------------------------------------------------------------------------
module paf_sqrt import paf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              valid_in,
	input  logic [D_W-1:0]    d_in,
	input  side_t             side_in,
	output logic              valid_out,
	output logic [D_W-1:0]    d_out,
	output logic [ROOT_W-1:0] root_out,
	output side_t             side_out
);

	logic              v_s    [SQRT_STEPS];
	logic [D_W-1:0]    rem_s  [SQRT_STEPS];
	logic [SQRT_W-1:0] res_s  [SQRT_STEPS];
	logic [D_W-1:0]    d_s    [SQRT_STEPS];
	side_t             side_s [SQRT_STEPS];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		localparam logic [SQRT_W-1:0] STEP_BIT = SQRT_W'(1) << (2 * (SQRT_STEPS - 1 - k));

		logic              v_i;
		logic [D_W-1:0]    rem_i;
		logic [SQRT_W-1:0] res_i;
		logic [D_W-1:0]    d_i;
		side_t             side_i;
		logic [SQRT_W-1:0] trial;
		logic              take;

		// Stage input comes from the port or from the previous stage.
		if (k == 0) begin : g_first
			assign v_i    = valid_in;
			assign rem_i  = d_in;
			assign res_i  = '0;
			assign d_i    = d_in;
			assign side_i = side_in;
		end else begin : g_next
			assign v_i    = v_s[k-1];
			assign rem_i  = rem_s[k-1];
			assign res_i  = res_s[k-1];
			assign d_i    = d_s[k-1];
			assign side_i = side_s[k-1];
		end

		// Trial subtraction for this root bit.
		assign trial = res_i + STEP_BIT;
		assign take  = SQRT_W'(rem_i) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? rem_i - trial[D_W-1:0] : rem_i;
				res_s[k]  <= take ? (res_i >> 1) + STEP_BIT : res_i >> 1;
				d_s[k]    <= d_i;
				side_s[k] <= side_i;
			end
		end
	end

	assign valid_out = v_s[SQRT_STEPS-1];
	assign d_out     = d_s[SQRT_STEPS-1];
	assign root_out  = res_s[SQRT_STEPS-1][ROOT_W-1:0];
	assign side_out  = side_s[SQRT_STEPS-1];

`ifndef SYNTHESIS
	// The root is the floor of the square root of the operand.
	a_root_floor: assert property (@(posedge clk) disable iff (!arst_n)
		valid_out |-> ((2*SQRT_W)'(root_out) * (2*SQRT_W)'(root_out) <= (2*SQRT_W)'(d_out))
			&& (((2*SQRT_W)'(root_out) + 1) * ((2*SQRT_W)'(root_out) + 1) > (2*SQRT_W)'(d_out)))
		else $error("square root stage gave a wrong root");
`endif

endmodule

### hdl/paf_div.sv
// ----------------------------------------------------------------------------
// Point attraction force: pipelined dual divider
// Restoring division of strength times magnitude times 2^40 by D times root
// for both axes, one quotient bit per stage, with the quotient held at 2^40.
// ----------------------------------------------------------------------------
module paf_div import paf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             valid_in,
	input  logic [DEN_W-1:0] den_in,
	input  side_t            side_in,
	output logic             valid_out,
	output logic [QF_W-1:0]  q_x_out,
	output logic [QF_W-1:0]  q_y_out,
	output side_t            side_out
);

	localparam logic [QF_W-1:0] QCAP = QF_W'(1) << QUO_W;

	function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] rem,
		input logic [DEN_W-1:0] den);
		logic [REM_W-1:0] sh;
		logic             ge;
		sh = {rem[REM_W-2:0], 1'b0};
		ge = sh >= REM_W'(den);
		return {ge, ge ? sh - REM_W'(den) : sh};
	endfunction

	// Entry stage: overflow and zero checks.
	logic             v_s0;
	logic [DEN_W-1:0] den_s0;
	logic [REM_W-1:0] rem_x_s0, rem_y_s0;
	logic             cap_x_s0, cap_y_s0, zero_x_s0, zero_y_s0;
	side_t            side_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else if (en) begin
			v_s0 <= valid_in;
		end
	end

	// The quotient reaches the cap exactly when the product is at least the divisor.
	always_ff @(posedge clk) begin
		if (en) begin
			den_s0    <= den_in;
			rem_x_s0  <= REM_W'(side_in.p_x);
			rem_y_s0  <= REM_W'(side_in.p_y);
			cap_x_s0  <= DEN_W'(side_in.p_x) >= den_in;
			cap_y_s0  <= DEN_W'(side_in.p_y) >= den_in;
			zero_x_s0 <= side_in.p_x == '0;
			zero_y_s0 <= side_in.p_y == '0;
			side_s0   <= side_in;
		end
	end

	logic             v_s      [DIV_STEPS];
	logic [DEN_W-1:0] den_s    [DIV_STEPS];
	logic [REM_W-1:0] rem_x_s  [DIV_STEPS];
	logic [REM_W-1:0] rem_y_s  [DIV_STEPS];
	logic [QUO_W-1:0] q_x_s    [DIV_STEPS];
	logic [QUO_W-1:0] q_y_s    [DIV_STEPS];
	logic             cap_x_s  [DIV_STEPS];
	logic             cap_y_s  [DIV_STEPS];
	logic             zero_x_s [DIV_STEPS];
	logic             zero_y_s [DIV_STEPS];
	side_t            side_s   [DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic             v_i;
		logic [DEN_W-1:0] den_i;
		logic [REM_W-1:0] rem_x_i, rem_y_i;
		logic [QUO_W-1:0] q_x_i, q_y_i;
		logic             cap_x_i, cap_y_i, zero_x_i, zero_y_i;
		side_t            side_i;
		logic [REM_W:0]   nx, ny;

		if (k == 0) begin : g_first
			assign v_i      = v_s0;
			assign den_i    = den_s0;
			assign rem_x_i  = rem_x_s0;
			assign rem_y_i  = rem_y_s0;
			assign q_x_i    = '0;
			assign q_y_i    = '0;
			assign cap_x_i  = cap_x_s0;
			assign cap_y_i  = cap_y_s0;
			assign zero_x_i = zero_x_s0;
			assign zero_y_i = zero_y_s0;
			assign side_i   = side_s0;
		end else begin : g_next
			assign v_i      = v_s[k-1];
			assign den_i    = den_s[k-1];
			assign rem_x_i  = rem_x_s[k-1];
			assign rem_y_i  = rem_y_s[k-1];
			assign q_x_i    = q_x_s[k-1];
			assign q_y_i    = q_y_s[k-1];
			assign cap_x_i  = cap_x_s[k-1];
			assign cap_y_i  = cap_y_s[k-1];
			assign zero_x_i = zero_x_s[k-1];
			assign zero_y_i = zero_y_s[k-1];
			assign side_i   = side_s[k-1];
		end

		// One shift, compare and subtract per lane.
		assign nx = div_step(rem_x_i, den_i);
		assign ny = div_step(rem_y_i, den_i);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k]    <= den_i;
				rem_x_s[k]  <= nx[REM_W-1:0];
				rem_y_s[k]  <= ny[REM_W-1:0];
				q_x_s[k]    <= {q_x_i[QUO_W-2:0], nx[REM_W]};
				q_y_s[k]    <= {q_y_i[QUO_W-2:0], ny[REM_W]};
				cap_x_s[k]  <= cap_x_i;
				cap_y_s[k]  <= cap_y_i;
				zero_x_s[k] <= zero_x_i;
				zero_y_s[k] <= zero_y_i;
				side_s[k]   <= side_i;
			end
		end
	end

	// A zero pull wins over the cap, which only arises from a zero divisor then.
	assign q_x_out   = zero_x_s[DIV_STEPS-1] ? '0 :
		cap_x_s[DIV_STEPS-1] ? QCAP : {1'b0, q_x_s[DIV_STEPS-1]};
	assign q_y_out   = zero_y_s[DIV_STEPS-1] ? '0 :
		cap_y_s[DIV_STEPS-1] ? QCAP : {1'b0, q_y_s[DIV_STEPS-1]};
	assign valid_out = v_s[DIV_STEPS-1];
	assign side_out  = side_s[DIV_STEPS-1];

`ifndef SYNTHESIS
	// A proper division always leaves a remainder below the divisor.
	a_rem_x_below: assert property (@(posedge clk) disable iff (!arst_n)
		valid_out && !cap_x_s[DIV_STEPS-1] && !zero_x_s[DIV_STEPS-1]
			|-> rem_x_s[DIV_STEPS-1] < REM_W'(den_s[DIV_STEPS-1]))
		else $error("x divider remainder not below divisor");
	a_rem_y_below: assert property (@(posedge clk) disable iff (!arst_n)
		valid_out && !cap_y_s[DIV_STEPS-1] && !zero_y_s[DIV_STEPS-1]
			|-> rem_y_s[DIV_STEPS-1] < REM_W'(den_s[DIV_STEPS-1]))
		else $error("y divider remainder not below divisor");
`endif

endmodule

### hdl/point_attraction_force_core.sv
// ----------------------------------------------------------------------------
// Point attraction force core
// Adds a softened inverse-square pull toward a configured centre to each
// particle's acceleration, saturating to signed Q16.16.
// ----------------------------------------------------------------------------
// Usage:
// Particles arrive on in_ch (position in Q4.20, acceleration in Q16.16 and a
// last-particle mark); each transfer yields exactly one result on out_ch, in
// order, with the updated accelerations, a saturation flag and the mark.
// The four registers (centre x, centre y, strength, softening) are written
// through cfg_we, cfg_index and cfg_wdata; the user must do so only while
// no particle is in flight; the block does not enforce this. Throughput is
// one particle per cycle while the skid register is empty. A particle passes
// four front stages, 25 square root stages, two for the D times root product,
// 41 divider stages and two for the final sum and saturation before out_ch.
// When out_ch stalls, the pending result moves into a skid register and the
// pipeline freezes only while that register is occupied; nothing is lost or
// repeated. Reset empties the pipeline, clears the centre and strength and
// sets the softening to about 1e-4.
// ----------------------------------------------------------------------------
module point_attraction_force_core import paf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	paf_in_if.sink               in_ch,
	paf_out_if.source            out_ch
);

	localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	function automatic logic [ACC_W:0] clip_sum(input logic [SUM_W-1:0] s);
		logic ovf;
		logic [ACC_W:0] r;
		ovf = s[SUM_W-1:ACC_W-1] != {(SUM_W-ACC_W+1){s[SUM_W-1]}};
		if (!ovf) begin
			r = {1'b0, s[ACC_W-1:0]};
		end else begin
			r = {1'b1, s[SUM_W-1] ? ACC_MIN : ACC_MAX};
		end
		return r;
	endfunction

	cfg_regs_t cfg_q;
	logic      pipe_en;
	logic      skid_full_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x  <= '0;
			cfg_q.center_y  <= '0;
			cfg_q.strength  <= '0;
			cfg_q.softening <= SOFT_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_CENTER_X:  cfg_q.center_x  <= cfg_wdata[POS_W-1:0];
				REG_CENTER_Y:  cfg_q.center_y  <= cfg_wdata[POS_W-1:0];
				REG_STRENGTH:  cfg_q.strength  <= cfg_wdata[STR_W-1:0];
				REG_SOFTENING: cfg_q.softening <= cfg_wdata[SOFT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The whole pipeline advances unless the skid register holds a result.
	assign pipe_en     = !skid_full_q;
	assign in_ch.ready = pipe_en;

	logic             v_fr, v_rt, v_dv;
	logic [D_W-1:0]   d_fr, d_rt;
	logic [ROOT_W-1:0] root_rt;
	side_t            side_fr, side_rt, side_dv;
	logic [QF_W-1:0]  q_x_dv, q_y_dv;

	paf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (pipe_en),
		.valid_in      (in_ch.valid),
		.pos_x         (in_ch.pos_x),
		.pos_y         (in_ch.pos_y),
		.accel_x_in    (in_ch.accel_x_in),
		.accel_y_in    (in_ch.accel_y_in),
		.last_particle (in_ch.last_particle),
		.cfg           (cfg_q),
		.valid_out     (v_fr),
		.d_out         (d_fr),
		.side_out      (side_fr)
	);

	paf_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.valid_in  (v_fr),
		.d_in      (d_fr),
		.side_in   (side_fr),
		.valid_out (v_rt),
		.d_out     (d_rt),
		.root_out  (root_rt),
		.side_out  (side_rt)
	);

	// Divisor D times root, as two 25 by 25 partial products and a sum.
	logic                      v_s1, v_s2;
	logic [D_W-1:0]            pp_lo_s1, pp_hi_s1;
	side_t                     side_s1, side_s2;
	logic [DEN_W-1:0]          den_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (pipe_en) begin
			v_s1 <= v_rt;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			pp_lo_s1 <= D_W'(d_rt[ROOT_SPLIT-1:0]) * D_W'(root_rt);
			pp_hi_s1 <= D_W'(d_rt[D_W-1:ROOT_SPLIT]) * D_W'(root_rt);
			side_s1  <= side_rt;
			den_s2   <= DEN_W'(pp_lo_s1) + (DEN_W'(pp_hi_s1) << ROOT_SPLIT);
			side_s2  <= side_s1;
		end
	end

	paf_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.valid_in  (v_s2),
		.den_in    (den_s2),
		.side_in   (side_s2),
		.valid_out (v_dv),
		.q_x_out   (q_x_dv),
		.q_y_out   (q_y_dv),
		.side_out  (side_dv)
	);

	// Signed contributions, then the saturating sums.
	logic             v_s3, v_s4;
	logic [CON_W-1:0] c_x_s3, c_y_s3;
	logic [ACC_W-1:0] ax_s3, ay_s3, ax_s4, ay_s4;
	logic             last_s3, last_s4, sat_s4;
	logic [SUM_W-1:0] sum_x_c, sum_y_c;
	logic [ACC_W:0]   clip_x_c, clip_y_c;

	assign sum_x_c  = {{(SUM_W-ACC_W){ax_s3[ACC_W-1]}}, ax_s3} + {c_x_s3[CON_W-1], c_x_s3};
	assign sum_y_c  = {{(SUM_W-ACC_W){ay_s3[ACC_W-1]}}, ay_s3} + {c_y_s3[CON_W-1], c_y_s3};
	assign clip_x_c = clip_sum(sum_x_c);
	assign clip_y_c = clip_sum(sum_y_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (pipe_en) begin
			v_s3 <= v_dv;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			c_x_s3  <= side_dv.neg_x ? -CON_W'(q_x_dv) : CON_W'(q_x_dv);
			c_y_s3  <= side_dv.neg_y ? -CON_W'(q_y_dv) : CON_W'(q_y_dv);
			ax_s3   <= side_dv.acc_x;
			ay_s3   <= side_dv.acc_y;
			last_s3 <= side_dv.last;
			ax_s4   <= clip_x_c[ACC_W-1:0];
			ay_s4   <= clip_y_c[ACC_W-1:0];
			sat_s4  <= clip_x_c[ACC_W] | clip_y_c[ACC_W];
			last_s4 <= last_s3;
		end
	end

	// Skid register: catches the result that the receiver did not take.
	logic [ACC_W-1:0] skid_ax_q, skid_ay_q;
	logic             skid_sat_q, skid_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (!skid_full_q && v_s4 && !out_ch.ready) begin
			skid_full_q <= 1'b1;
		end else if (skid_full_q && out_ch.ready) begin
			skid_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_full_q) begin
			skid_ax_q   <= ax_s4;
			skid_ay_q   <= ay_s4;
			skid_sat_q  <= sat_s4;
			skid_last_q <= last_s4;
		end
	end

	assign out_ch.valid       = skid_full_q | v_s4;
	assign out_ch.accel_x_out = skid_full_q ? skid_ax_q : ax_s4;
	assign out_ch.accel_y_out = skid_full_q ? skid_ay_q : ay_s4;
	assign out_ch.saturated   = skid_full_q ? skid_sat_q : sat_s4;
	assign out_ch.last_out    = skid_full_q ? skid_last_q : last_s4;

`ifndef SYNTHESIS
	// A held result stays held until the receiver takes it.
	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q && !out_ch.ready |=> skid_full_q)
		else $error("skid register dropped a pending result");
	// A taken skid result frees the register at once.
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q && out_ch.ready |=> !skid_full_q)
		else $error("skid register kept a delivered result");
	// The frozen pipeline keeps its final stage unchanged.
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!pipe_en |=> $stable(v_s4) && $stable(ax_s4) && $stable(ay_s4))
		else $error("final stage moved while the pipeline was frozen");
`endif

endmodule
